// ===== rtl/ltx_pkg.sv =====
// ltx_pkg: shared constants, register codes and transfer structs for the
// loop tail crossfader. No dependencies; every rtl file but ltx_ram imports it.
package ltx_pkg;

   localparam int MAX_FADE     = 2048;
   localparam int MAX_CHANNELS = 2;

   localparam int SAMPLE_W   = 24;
   localparam int LEN_W      = 24;
   localparam int FADE_LEN_W = 12;
   localparam int WEIGHT_W   = 17;
   localparam int NUM_CH_W   = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam int HEAD_DEPTH = MAX_FADE * MAX_CHANNELS;
   localparam int HEAD_AW    = $clog2(HEAD_DEPTH);
   localparam int FADE_AW    = $clog2(MAX_FADE);
   localparam int CH_W       = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int CMP_W      = CH_W + 2;

   localparam logic [WEIGHT_W-1:0] ONE_Q16 = WEIGHT_W'(65536);
   localparam int PCM_SCALE = 32767;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_FADE_ENABLE,
      REG_REGION_LENGTH,
      REG_FADE_LENGTH,
      REG_FADE_STEP,
      REG_NUM_CHANNELS,
      REG_OUTPUT_16BIT
   } ltx_reg_type;

   // sample on its way from the control stage into the blend datapath
   typedef struct packed {
      logic                       valid;
      logic signed [SAMPLE_W-1:0] sample;
      logic [WEIGHT_W-1:0]        weight;
      logic                       blend;
      logic                       pcm;
      logic                       last;
   } ltx_item_type;

   // head store access, one per accepted sample at most
   typedef struct packed {
      logic                we;
      logic                re;
      logic [HEAD_AW-1:0]  addr;
      logic [SAMPLE_W-1:0] wdata;
   } ltx_mem_req_type;

endpackage

// ===== rtl/ltx_req_if.sv =====
// ltx_req_if: input sample channel, valid/ready handshake.
// Depends on ltx_pkg for the sample width.
interface ltx_req_if import ltx_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink (input valid, input sample_in, output ready);
endinterface

// ===== rtl/ltx_rsp_if.sv =====
// ltx_rsp_if: result sample channel, valid/ready handshake.
// Depends on ltx_pkg for the sample width.
interface ltx_rsp_if import ltx_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample_out;
   logic                       last;

   modport source (output valid, output sample_out, output last, input ready);
   modport sink (input valid, input sample_out, input last, output ready);
endinterface

// ===== rtl/ltx_ram.sv =====
// ltx_ram: generic single-port synchronous ram with registered read.
// No package dependency.
module ltx_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/ltx_ctrl.sv =====
// ltx_ctrl: configuration registers, frame/channel counters, fade weight
// and head store addressing. Depends on ltx_pkg.
module ltx_ctrl import ltx_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  logic                       accept,
   input  logic signed [SAMPLE_W-1:0] sample_in,
   input  logic                       csr_we,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_wdata,
   output ltx_item_type               item,
   output ltx_mem_req_type            mem_req
);

   localparam int SUM_W = LEN_W + 1;
   localparam int NW_W  = WEIGHT_W + 1;

   logic                  fade_enable_ff;
   logic [LEN_W-1:0]      region_length_ff;
   logic [FADE_LEN_W-1:0] fade_length_ff;
   logic [WEIGHT_W-1:0]   fade_step_ff;
   logic [NUM_CH_W-1:0]   num_channels_ff;
   logic                  output_16bit_ff;

   logic [LEN_W-1:0]    frame_ff, frame_in;
   logic [CH_W-1:0]     chan_ff, chan_in;
   logic [WEIGHT_W-1:0] weight_ff, weight_in;
   ltx_item_type        item_ff;

   logic [LEN_W-1:0]   len;
   logic [CMP_W-1:0]   nch;
   logic               frame_done;
   logic               active;
   logic               in_head;
   logic               in_tail;
   logic               at_final;
   logic [SUM_W-1:0]   sum_fk;
   logic [SUM_W-1:0]   tail_off;
   logic [HEAD_AW-1:0] head_addr;
   logic [HEAD_AW-1:0] tail_addr;
   logic [NW_W-1:0]    weight_sum;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         fade_enable_ff   <= 1'b0;
         region_length_ff <= LEN_W'(1);
         fade_length_ff   <= '0;
         fade_step_ff     <= '0;
         num_channels_ff  <= NUM_CH_W'(1);
         output_16bit_ff  <= 1'b1;
      end else if (csr_we) begin
         case (ltx_reg_type'(csr_index))
            REG_FADE_ENABLE:   fade_enable_ff   <= csr_wdata[0];
            REG_REGION_LENGTH: region_length_ff <= csr_wdata[LEN_W-1:0];
            REG_FADE_LENGTH:   fade_length_ff   <= csr_wdata[FADE_LEN_W-1:0];
            REG_FADE_STEP:     fade_step_ff     <= csr_wdata[WEIGHT_W-1:0];
            REG_NUM_CHANNELS:  num_channels_ff  <= csr_wdata[NUM_CH_W-1:0];
            REG_OUTPUT_16BIT:  output_16bit_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // region decode
   always_comb begin
      len = (region_length_ff == '0) ? LEN_W'(1) : region_length_ff;
      if (num_channels_ff == '0) begin
         nch = CMP_W'(1);
      end else if (CMP_W'(num_channels_ff) > CMP_W'(MAX_CHANNELS)) begin
         nch = CMP_W'(MAX_CHANNELS);
      end else begin
         nch = CMP_W'(num_channels_ff);
      end
      frame_done = (CMP_W'(chan_ff) + CMP_W'(1)) >= nch;
      active = fade_enable_ff && (fade_length_ff > FADE_LEN_W'(1))
               && (LEN_W'({fade_length_ff, 1'b0}) <= len)
               && (32'(fade_length_ff) <= MAX_FADE);
      in_head  = active && (LEN_W'(fade_length_ff) > frame_ff);
      sum_fk   = SUM_W'(frame_ff) + SUM_W'(fade_length_ff);
      in_tail  = active && !in_head && (sum_fk >= SUM_W'(len)) && (frame_ff < len);
      at_final = frame_ff == (len - LEN_W'(1));
      tail_off = sum_fk - SUM_W'(len);
      head_addr = HEAD_AW'(frame_ff[FADE_AW-1:0]) * HEAD_AW'(MAX_CHANNELS)
                  + HEAD_AW'(chan_ff);
      tail_addr = HEAD_AW'(tail_off[FADE_AW-1:0]) * HEAD_AW'(MAX_CHANNELS)
                  + HEAD_AW'(chan_ff);
      weight_sum = NW_W'(weight_ff) + NW_W'(fade_step_ff);
   end

   always_comb begin
      mem_req.we    = accept && in_head;
      mem_req.re    = accept && in_tail;
      mem_req.addr  = in_head ? head_addr : tail_addr;
      mem_req.wdata = sample_in;
   end

   // counter and weight update
   always_comb begin
      frame_in  = frame_ff;
      chan_in   = chan_ff;
      weight_in = weight_ff;
      if (accept) begin
         if (frame_done) begin
            chan_in = '0;
            if (in_tail && !at_final) begin
               weight_in = (weight_sum > NW_W'(ONE_Q16)) ? ONE_Q16
                                                         : weight_sum[WEIGHT_W-1:0];
            end
            if ((SUM_W'(frame_ff) + SUM_W'(1)) >= SUM_W'(len)) begin
               frame_in  = '0;
               weight_in = '0;
            end else begin
               frame_in = frame_ff + LEN_W'(1);
            end
         end else begin
            chan_in = chan_ff + CH_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff  <= '0;
         chan_ff   <= '0;
         weight_ff <= '0;
      end else begin
         frame_ff  <= frame_in;
         chan_ff   <= chan_in;
         weight_ff <= weight_in;
      end
   end

   // hand-off register into the datapath, aligned with the ram read
   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff.valid <= 1'b0;
      end else if (advance) begin
         item_ff.valid <= accept;
      end
      if (advance && accept) begin
         item_ff.sample <= sample_in;
         item_ff.weight <= at_final ? ONE_Q16 : weight_ff;
         item_ff.blend  <= in_tail;
         item_ff.pcm    <= output_16bit_ff;
         item_ff.last   <= (frame_ff >= (len - LEN_W'(1))) && frame_done;
      end
   end

   assign item = item_ff;

endmodule

// ===== rtl/ltx_blend.sv =====
// ltx_blend: blend multiply, rounding, 16-bit scaling and output register.
// Depends on ltx_pkg.
module ltx_blend import ltx_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  ltx_item_type               item,
   input  logic [SAMPLE_W-1:0]        head,
   output logic                       out_valid,
   output logic signed [SAMPLE_W-1:0] out_sample,
   output logic                       out_last
);

   localparam int DIFF_W  = SAMPLE_W + 1;
   localparam int PROD_W  = DIFF_W + WEIGHT_W + 1;
   localparam int ACC_W   = PROD_W + 1;
   localparam int SCALE_W = SAMPLE_W + 16;
   localparam int PCM_W   = 16;

   // stage 2: weight times (head - tail)
   logic signed [DIFF_W-1:0]   diff;
   logic signed [WEIGHT_W:0]   wgt;
   logic signed [PROD_W-1:0]   prod;
   logic                       s2_valid_ff;
   logic signed [SAMPLE_W-1:0] s2_sample_ff;
   logic signed [PROD_W-1:0]   s2_prod_ff;
   logic                       s2_blend_ff, s2_pcm_ff, s2_last_ff;

   // stage 3: round to nearest, magnitude for pcm scaling
   logic signed [ACC_W-1:0]    acc;
   logic signed [SAMPLE_W-1:0] mixed;
   logic [SAMPLE_W-1:0]        mag;
   logic                       s3_valid_ff;
   logic signed [SAMPLE_W-1:0] s3_mixed_ff;
   logic [SAMPLE_W-1:0]        s3_mag_ff;
   logic                       s3_neg_ff, s3_pcm_ff, s3_last_ff;

   // output
   logic [SCALE_W-1:0]         scaled;
   logic [SAMPLE_W-1:0]        q_wide;
   logic signed [SAMPLE_W-1:0] result;
   logic                       out_valid_ff;
   logic signed [SAMPLE_W-1:0] out_sample_ff;
   logic                       out_last_ff;

   always_comb begin
      diff = $signed({head[SAMPLE_W-1], head}) - DIFF_W'(item.sample);
      wgt  = $signed({1'b0, item.weight});
      prod = wgt * diff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= item.valid;
      end
      if (advance) begin
         s2_sample_ff <= item.sample;
         s2_prod_ff   <= prod;
         s2_blend_ff  <= item.blend;
         s2_pcm_ff    <= item.pcm;
         s2_last_ff   <= item.last;
      end
   end

   // tail * 65536 + w * (head - tail), halves rounded up
   always_comb begin
      acc = $signed({{(ACC_W - SAMPLE_W - 16){s2_sample_ff[SAMPLE_W-1]}},
                     s2_sample_ff, 16'b0})
            + ACC_W'(s2_prod_ff) + ACC_W'(32768);
      mixed = s2_blend_ff ? acc[SAMPLE_W+15:16] : s2_sample_ff;
      mag   = mixed[SAMPLE_W-1] ? (~mixed + SAMPLE_W'(1)) : mixed;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (advance) begin
         s3_mixed_ff <= mixed;
         s3_mag_ff   <= mag;
         s3_neg_ff   <= mixed[SAMPLE_W-1];
         s3_pcm_ff   <= s2_pcm_ff;
         s3_last_ff  <= s2_last_ff;
      end
   end

   // magnitude * 32767 / 2^23, rounded half away from zero via the sign
   always_comb begin
      scaled = SCALE_W'(s3_mag_ff) * SCALE_W'(PCM_SCALE) + SCALE_W'(1 << 22);
      q_wide = SAMPLE_W'(scaled[23+PCM_W-1:23]);
      if (s3_pcm_ff) begin
         result = s3_neg_ff ? (~q_wide + SAMPLE_W'(1)) : q_wide;
      end else begin
         result = s3_mixed_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= s3_valid_ff;
      end
      if (advance) begin
         out_sample_ff <= result;
         out_last_ff   <= s3_last_ff;
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_sample = out_sample_ff;
   assign out_last   = out_last_ff;

endmodule

// ===== rtl/loop_tail_crossfader.sv =====
// loop_tail_crossfader: top level of the loop tail crossfader.
// Depends on ltx_pkg, ltx_req_if, ltx_rsp_if, ltx_ram, ltx_ctrl, ltx_blend.
//
//   channel   dir   handshake      payload
//   req_ch    in    valid/ready    sample_in (s24, q1.23)
//   rsp_ch    out   valid/ready    sample_out (s24), last
//   csr_*     in    csr_we only    csr_index (3), csr_wdata (24)
//
// one sample per cycle sustained while rsp_ch is not stalled; a transaction taken on
// req_ch is offered on rsp_ch after passing the pipeline (head read with hand-off
// register, multiply, round, pcm scale into the output register)
// the rate is bounded by the single head store port, touched at most once per sample
// reset clears counters, weight and valid bits; the head store needs no sweep
// a stalled rsp_ch freezes every stage at once, so req_ch.ready drops with it
module loop_tail_crossfader import ltx_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   ltx_req_if.sink               req_ch,
   ltx_rsp_if.source             rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic            advance;
   logic            accept;
   logic            out_valid;
   ltx_item_type    item;
   ltx_mem_req_type mem_req;
   logic [SAMPLE_W-1:0] head;

   // whole pipeline moves whenever the output register is free or draining
   assign advance      = !out_valid || rsp_ch.ready;
   assign accept       = req_ch.valid && advance;
   assign req_ch.ready = advance;
   assign rsp_ch.valid = out_valid;

   // counters, config and head store addressing
   ltx_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .accept    (accept),
      .sample_in (req_ch.sample_in),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .item      (item),
      .mem_req   (mem_req)
   );

   // head samples, written during the first fade frames, read in the tail
   ltx_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (HEAD_DEPTH)
   ) u_head_ram (
      .clock (clock),
      .we    (mem_req.we),
      .re    (mem_req.re),
      .addr  (mem_req.addr),
      .wdata (mem_req.wdata),
      .rdata (head)
   );

   // blend and output formatting
   ltx_blend u_blend (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .item       (item),
      .head       (head),
      .out_valid  (out_valid),
      .out_sample (rsp_ch.sample_out),
      .out_last   (rsp_ch.last)
   );

endmodule
